// ===== rtl/core/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg: shared types for the run-length burst expander
// register indexes, count modes, element widths and result status codes
// ----------------------------------------------------------------------------
package rbe_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COUNT_MODE      = 3'd0,
    REG_VALUE_WIDTH     = 3'd1,
    REG_BIG_ENDIAN      = 3'd2,
    REG_OUTPUT_CAPACITY = 3'd3,
    REG_MAX_RUN         = 3'd4
  } reg_idx_e;

  // count word interpretation, the spare code behaves as cumulative
  typedef enum logic [1:0] {
    CNT_DIRECT8  = 2'd0,
    CNT_DIRECT16 = 2'd1,
    CNT_CUMUL32  = 2'd2,
    CNT_SPARE    = 2'd3
  } count_mode_e;

  // element width, the spare code behaves as 32 bit
  typedef enum logic [1:0] {
    VW_8     = 2'd0,
    VW_16    = 2'd1,
    VW_32    = 2'd2,
    VW_SPARE = 2'd3
  } value_width_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_REFUSED   = 2'd3
  } status_e;

  // input item kind
  typedef enum logic {
    ACT_RUN    = 1'b0,
    ACT_RESUME = 1'b1
  } action_e;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned RegIdxWidth = 3;

endpackage

// ===== rtl/core/rle_burst_expander.sv =====
// ----------------------------------------------------------------------------
// rle_burst_expander: run-length decoder producing fill descriptors
// turns count/value items into fills of value x length at the output position
// ----------------------------------------------------------------------------
// Each accepted item goes to an input register; once the output side has room,
// the state (output position, cumulative base, pending remainder) is updated
// and at most one fill descriptor is loaded into the output register. The block
// takes one item every clock cycle while the output side is not stalled. The
// per-item path is one 32-bit subtract for the cumulative run, a compare against
// max_run, the capacity clip compare and the position add; the state loop closes
// through that combinational path. The input register stalls only while a
// finished descriptor waits on the output side. Run items are refused (status
// refused, length zero) while a clipped remainder is pending; a resume item
// restarts the buffer at position zero and emits the remainder. Configuration is
// written through a plain write port and must only change while the block is
// idle.
module rle_burst_expander #(
  parameter int unsigned POSITION_WIDTH = 32  // output position width, 8 to 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [rbe_pkg::RegIdxWidth-1:0] cfg_addr_i,
  input  logic [rbe_pkg::WordWidth-1:0]   cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // count_word [31:0], value [63:32]
  input  logic        s_axis_tuser,  // action [0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // fill_value [31:0], fill_start [63:32],
                                     // fill_length [95:64]
  output logic [1:0]  m_axis_tuser   // status [1:0]
);
  import rbe_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  // largest position, also the saturation limit of the capacity
  localparam logic [31:0] PosMax = 32'((64'd1 << PW) - 64'd1);

  // configuration registers
  count_mode_e  count_mode_q;
  value_width_e value_width_q;
  logic         big_endian_q;
  logic [31:0]  out_cap_q;
  logic [31:0]  max_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q  <= CNT_DIRECT8;
      value_width_q <= VW_8;
      big_endian_q  <= 1'b0;
      out_cap_q     <= '0;
      max_run_q     <= 32'd65535;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_COUNT_MODE:      count_mode_q  <= count_mode_e'(cfg_wdata_i[1:0]);
        REG_VALUE_WIDTH:     value_width_q <= value_width_e'(cfg_wdata_i[1:0]);
        REG_BIG_ENDIAN:      big_endian_q  <= cfg_wdata_i[0];
        REG_OUTPUT_CAPACITY: out_cap_q     <= cfg_wdata_i;
        REG_MAX_RUN:         max_run_q     <= cfg_wdata_i;
        default:             ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  action_e     in_action_q;
  logic [31:0] in_word_q;
  logic [31:0] in_value_q;
  logic        advance;

  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= action_e'(s_axis_tuser);
      in_word_q   <= s_axis_tdata[31:0];
      in_value_q  <= s_axis_tdata[63:32];
    end
  end

  // decoder state
  logic [31:0]   prev_count_q, prev_count_d;
  logic          base_loaded_q, base_loaded_d;
  logic [PW-1:0] out_pos_q, out_pos_d;
  logic [31:0]   remainder_q, remainder_d;
  logic          pending_q, pending_d;
  logic [31:0]   pending_val_q, pending_val_d;

  // output register
  logic        m_valid_q;
  logic [31:0] m_value_q, m_start_q, m_length_q;
  status_e     m_status_q;

  // the item in the input register moves on once the output side has room
  assign advance = in_valid_q && (!m_valid_q || m_axis_tready);

  // per-item datapath
  logic          res_valid;
  logic [31:0]   res_value, res_length;
  logic [PW-1:0] res_start;
  status_e       res_status;

  logic [31:0]   val_masked;
  logic [31:0]   cum_word;
  logic [31:0]   cum_run;
  logic [15:0]   word16;
  logic [PW-1:0] cap_eff;
  logic [PW-1:0] emit_pos;
  logic [PW-1:0] avail;
  logic [31:0]   emit_len;
  logic [31:0]   emit_val;
  logic          do_emit;
  logic          fits;

  always_comb begin
    case (value_width_q)
      VW_8:    val_masked = {24'd0, in_value_q[7:0]};
      VW_16:   val_masked = {16'd0, in_value_q[15:0]};
      default: val_masked = in_value_q;
    endcase

    word16   = big_endian_q ? {in_word_q[7:0], in_word_q[15:8]} : in_word_q[15:0];
    cum_word = big_endian_q ? {in_word_q[7:0], in_word_q[15:8],
                               in_word_q[23:16], in_word_q[31:24]} : in_word_q;
    cum_run  = cum_word - prev_count_q;

    cap_eff  = PW'((out_cap_q > PosMax) ? PosMax : out_cap_q);
    // a resume restarts the buffer at position zero
    emit_pos = (in_action_q == ACT_RESUME) ? '0 : out_pos_q;
    avail    = (cap_eff > emit_pos) ? (cap_eff - emit_pos) : '0;

    prev_count_d  = prev_count_q;
    base_loaded_d = base_loaded_q;
    out_pos_d     = out_pos_q;
    remainder_d   = remainder_q;
    pending_d     = pending_q;
    pending_val_d = pending_val_q;

    res_valid  = 1'b0;
    res_value  = val_masked;
    res_start  = out_pos_q;
    res_length = '0;
    res_status = ST_OK;
    do_emit    = 1'b0;
    emit_len   = '0;
    emit_val   = val_masked;

    if (in_action_q == ACT_RESUME) begin
      out_pos_d = '0;
      if (pending_q) begin
        do_emit  = 1'b1;
        emit_len = remainder_q;
        emit_val = pending_val_q;
      end
    end else if (pending_q) begin
      res_valid  = 1'b1;
      res_status = ST_REFUSED;
    end else begin
      case (count_mode_q)
        CNT_DIRECT8: begin
          emit_len = {24'd0, in_word_q[7:0]};
          do_emit  = (emit_len != '0);
        end
        CNT_DIRECT16: begin
          emit_len = {16'd0, word16};
          do_emit  = (emit_len != '0);
        end
        default: begin
          if (!base_loaded_q) begin
            // first cumulative word only sets the base
            prev_count_d  = cum_word;
            base_loaded_d = 1'b1;
          end else if (cum_run > max_run_q) begin
            res_valid  = 1'b1;
            res_status = ST_BAD_COUNT;
          end else begin
            prev_count_d = cum_word;
            emit_len     = cum_run;
            do_emit      = (cum_run != '0);
          end
        end
      endcase
    end

    fits = (emit_len <= 32'(avail));
    if (do_emit) begin
      res_valid = 1'b1;
      res_value = emit_val;
      res_start = emit_pos;
      if (fits) begin
        res_length  = emit_len;
        res_status  = ST_OK;
        out_pos_d   = emit_pos + PW'(emit_len);
        remainder_d = '0;
        pending_d   = 1'b0;
      end else begin
        // clip at the end of the buffer and hold the rest back
        res_length    = 32'(avail);
        res_status    = ST_SHORT;
        out_pos_d     = emit_pos + avail;
        remainder_d   = emit_len - 32'(avail);
        pending_d     = 1'b1;
        pending_val_d = emit_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q  <= '0;
      base_loaded_q <= 1'b0;
      out_pos_q     <= '0;
      remainder_q   <= '0;
      pending_q     <= 1'b0;
      pending_val_q <= '0;
    end else if (advance) begin
      prev_count_q  <= prev_count_d;
      base_loaded_q <= base_loaded_d;
      out_pos_q     <= out_pos_d;
      remainder_q   <= remainder_d;
      pending_q     <= pending_d;
      pending_val_q <= pending_val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      m_value_q  <= res_value;
      m_start_q  <= 32'(res_start);
      m_length_q <= res_length;
      m_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_length_q, m_start_q, m_value_q};
  assign m_axis_tuser  = m_status_q;

endmodule

// ===== rtl/core/rbe_checker.sv =====
// ----------------------------------------------------------------------------
// rbe_checker: port-level checks for the run-length burst expander
// watches the output stream and the input handshake over time
// ----------------------------------------------------------------------------
module rbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import rbe_pkg::*;

  // refused and invalid-count results never describe elements
  a_no_len_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_REFUSED || m_axis_tuser == ST_BAD_COUNT)
    |-> m_axis_tdata[95:64] == 32'd0)
    else $error("error status with non-zero fill length");

  // a full fill always has elements, zero runs give no result
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |-> m_axis_tdata[95:64] != 32'd0)
    else $error("ok fill with zero length");

  // fills stay inside the position range, positions never wrap
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[63:32]} + {1'b0, m_axis_tdata[95:64]})
                      <= 33'h0_FFFF_FFFF)
    else $error("fill runs past the largest position");

  // a stalled result keeps its content
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // with the output side ready the input side never blocks
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although output is ready");

endmodule

bind rle_burst_expander rbe_checker u_rbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
